### rtl/smv_pkg.sv
package smv_pkg;

  // Field and accumulator widths
  localparam int unsigned IN_W   = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned SUM_W  = 33;
  localparam int unsigned SQ_W   = 47;
  localparam int unsigned MEAN_W = 24;
  localparam int unsigned VAR_W  = 39;
  // Products and the final difference wrap at 64 bits
  localparam int unsigned PROD_W = 64;
  // Divisor: n*(n-1) needs twice the count width
  localparam int unsigned DVR_W  = 2 * CNT_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc_en;       // accumulate the current input word
    logic capture_prod; // register n*sumsq, |sum|^2 and n*(n-1)
    logic capture_diff; // register n*sumsq - |sum|^2
    logic div_start;    // launch the divider
    logic div_sel_var;  // 0: mean operands, 1: variance operands
    logic take_mean;    // store the mean quotient
    logic take_var;     // store the variance quotient
    logic load_out;     // load the output word and clear the set
  } smv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic var_ok;       // at least two samples in the set
    logic out_free;     // output register can take a word this cycle
  } smv_sts_t;

endpackage

### rtl/smv_if.sv
// Sample channel
interface smv_in_if;
  import smv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  sample;
  logic                    last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

// Result channel
interface smv_out_if;
  import smv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_value;
  logic        [VAR_W-1:0]  variance_value;
  logic                     variance_valid;
  logic        [CNT_W-1:0]  sample_count;
  logic                     count_overflow;

  modport source (output valid, mean_value, variance_value, variance_valid,
                  sample_count, count_overflow, input ready);
  modport sink   (input valid, mean_value, variance_value, variance_valid,
                  sample_count, count_overflow, output ready);
endinterface

### rtl/smv_div.sv
// Restoring divider, one quotient bit per cycle
module smv_div #(
  parameter int unsigned DVD_W = 72,
  parameter int unsigned DVR_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quot_o,
  output logic             done_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVR_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVR_W-1:0] dvr_q, dvr_d;

  logic [DVR_W:0]   trial;
  logic [DVR_W:0]   diff;
  logic             ge;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvr_q};
  assign ge    = ~diff[DVR_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvr_d  = dvr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvr_q <= dvr_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

  // a launch always starts a run
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");

endmodule

### rtl/smv_dpath.sv
// Accumulators, product and difference registers, divider and output word
module smv_dpath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_COUNT   = 65535,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  smv_pkg::smv_cmd_t                cmd_i,
  output smv_pkg::smv_sts_t                sts_o,
  input  logic signed [smv_pkg::IN_W-1:0]  sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [smv_pkg::MEAN_W-1:0] mean_value_o,
  output logic [smv_pkg::VAR_W-1:0]        variance_value_o,
  output logic                             variance_valid_o,
  output logic [smv_pkg::CNT_W-1:0]        sample_count_o,
  output logic                             count_overflow_o
);
  import smv_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned DVD_W = PROD_W + FRAC_BITS;

  // accumulators
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q;
  logic              ovf_q;

  // finalization registers
  logic [PROD_W-1:0] nsq_q;
  logic [PROD_W-1:0] mag2_q;
  logic [DVR_W-1:0]  m_q;
  logic [PROD_W-1:0] d_q;
  logic [MEAN_W-1:0] mean_res_q;
  logic [VAR_W-1:0]  var_res_q;

  // output word
  logic              out_valid_q;
  logic [MEAN_W-1:0] out_mean_q;
  logic [VAR_W-1:0]  out_var_q;
  logic              out_vok_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_ovf_q;

  // sample decode: low SB bits as two's complement
  logic [SB-1:0]     s_bits;
  logic [SB-1:0]     s_mag;
  logic [SUM_W-1:0]  s_ext;
  logic [2*SB-1:0]   s_sq;

  assign s_bits = SB'($unsigned(sample_i));
  assign s_mag  = s_bits[SB-1] ? (~s_bits + SB'(1)) : s_bits;
  assign s_ext  = {{(SUM_W-SB){s_bits[SB-1]}}, s_bits};
  assign s_sq   = (2*SB)'(s_mag) * (2*SB)'(s_mag);

  // sum magnitude and products for the final step
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [CNT_W+SQ_W-1:0]    nsq;
  logic [2*SUM_W-1:0]       mag2;
  logic [DVR_W-1:0]         m_prod;

  assign sum_neg = sum_q[SUM_W-1];
  assign sum_mag = sum_neg ? (~sum_q + SUM_W'(1)) : sum_q;
  assign nsq     = (CNT_W+SQ_W)'(cnt_q) * (CNT_W+SQ_W)'(sq_q);
  assign mag2    = (2*SUM_W)'(sum_mag) * (2*SUM_W)'(sum_mag);
  assign m_prod  = DVR_W'(cnt_q) * DVR_W'(cnt_q - CNT_W'(1));

  // divider operands
  logic [DVD_W-1:0] dvd;
  logic [DVR_W-1:0] dvr;
  logic [DVD_W-1:0] quot;
  logic             div_done;

  assign dvd = cmd_i.div_sel_var ? (DVD_W'(d_q) << FRAC_BITS)
                                 : (DVD_W'(sum_mag) << FRAC_BITS);
  assign dvr = cmd_i.div_sel_var ? m_q : DVR_W'(cnt_q);

  smv_div #(
    .DVD_W (DVD_W),
    .DVR_W (DVR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvr),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  logic [MEAN_W-1:0] mean_abs;
  assign mean_abs = quot[MEAN_W-1:0];

  // accumulators and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_out) begin
        cnt_q <= '0;
        sum_q <= '0;
        sq_q  <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.acc_en) begin
        if (cnt_q < CNT_W'(MAX_COUNT)) begin
          cnt_q <= cnt_q + CNT_W'(1);
          sum_q <= sum_q + s_ext;
          sq_q  <= sq_q + SQ_W'(s_sq);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // finalization and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_prod) begin
      nsq_q  <= PROD_W'(nsq);
      mag2_q <= mag2[PROD_W-1:0];
      m_q    <= m_prod;
    end
    if (cmd_i.capture_diff) begin
      d_q <= nsq_q - mag2_q;
    end
    if (cmd_i.take_mean) begin
      mean_res_q <= sum_neg ? (~mean_abs + MEAN_W'(1)) : mean_abs;
      var_res_q  <= '0;
    end
    if (cmd_i.take_var) begin
      var_res_q <= quot[VAR_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_mean_q <= mean_res_q;
      out_var_q  <= var_res_q;
      out_vok_q  <= sts_o.var_ok;
      out_cnt_q  <= cnt_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.var_ok   = (cnt_q >= CNT_W'(2));
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign mean_value_o     = $signed(out_mean_q);
  assign variance_value_o = out_var_q;
  assign variance_valid_o = out_vok_q;
  assign sample_count_o   = out_cnt_q;
  assign count_overflow_o = out_ovf_q;

  // a loaded word is presented next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("output word lost after load");

  // overflow only once the count is saturated
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CNT_W'(MAX_COUNT)))
    else $error("overflow flag without saturated count");

endmodule

### rtl/smv_ctrl.sv
// Sequencer: accumulate, form products, mean and (for n >= 2) variance division, hand off result
module smv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  smv_pkg::smv_sts_t sts_i,
  output smv_pkg::smv_cmd_t cmd_o
);
  import smv_pkg::*;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_PROD,
    ST_DIFF,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && in_last_i) state_d = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.capture_prod = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.capture_diff = 1'b1;
        state_d = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.take_mean = 1'b1;
          state_d = sts_i.var_ok ? ST_VAR_GO : ST_OUT;
        end
      end
      ST_VAR_GO: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_var = 1'b1;
        state_d = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        cmd_o.div_sel_var = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.take_var = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_ACC);

  // divider finishes only while a division is awaited
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_MEAN_WAIT || state_q == ST_VAR_WAIT))
    else $error("divider done outside a wait state");

endmodule

### rtl/sample_mean_variance_unit.sv
// Sample mean and unbiased variance of a set of signed samples.
//
// in_i carries one sample word per handshake, with last marking the final
// sample of a set. out_o carries one result word per set: the mean, sum/n
// truncated toward zero, and the variance, floor(2^F*(n*sumsq - sum^2) /
// (n*(n-1))), both with FRAC_BITS fraction bits, plus the count, a variance
// valid flag (low for a single sample) and a count overflow flag.
//
// Samples are accumulated at one per cycle while in_i is ready. After the
// last sample the block registers the products and then their difference,
// then runs a radix-2 restoring divider for the mean and, with two or more
// samples, again for the variance. in_i is not ready until the result is
// loaded into the output register, where it waits; the next set is
// accepted meanwhile, and a set that finishes before the receiver takes
// the earlier word waits for it. Reset clears all sums, the count and the
// output valid; no clearing pass is needed.
module sample_mean_variance_unit #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_COUNT   = 65535,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smv_in_if.sink     in_i,
  smv_out_if.source  out_o
);
  import smv_pkg::*;

  smv_cmd_t cmd;
  smv_sts_t sts;

  smv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smv_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COUNT   (MAX_COUNT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (in_i.sample),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .mean_value_o     (out_o.mean_value),
    .variance_value_o (out_o.variance_value),
    .variance_valid_o (out_o.variance_valid),
    .sample_count_o   (out_o.sample_count),
    .count_overflow_o (out_o.count_overflow)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Expected statistics of one finished set
typedef struct {
  logic signed [smv_pkg::MEAN_W-1:0] mean_value;
  logic        [smv_pkg::VAR_W-1:0]  variance_value;
  logic                              variance_valid;
  logic        [smv_pkg::CNT_W-1:0]  sample_count;
  logic                              count_overflow;
} set_stats_t;

// Accumulates each accepted sample word and checks each result word
class mean_var_scoreboard;
  localparam int unsigned MAX_SAMPLES = 65535;
  localparam int unsigned FRAC = 8;

  logic [smv_pkg::CNT_W-1:0] n_acc;
  logic [smv_pkg::SUM_W-1:0] sum_acc;
  logic [smv_pkg::SQ_W-1:0]  sq_acc;
  bit                        ovf_acc;
  set_stats_t                stats_q[$];
  int                        errors;

  function new();
    clear_set();
    errors = 0;
  endfunction

  function void clear_set();
    n_acc   = '0;
    sum_acc = '0;
    sq_acc  = '0;
    ovf_acc = 1'b0;
  endfunction

  function int pending();
    return stats_q.size();
  endfunction

  // Update the set with one sample; on the last one queue the statistics
  function void note_sample(logic signed [15:0] s, bit lst);
    int                        si;
    logic [63:0]               smag;
    logic [smv_pkg::SUM_W-1:0] mag33;
    logic [63:0]               nn, mag, mq, mean, d, m, q, r, var_v;
    bit                        neg;
    set_stats_t                st;
    si = int'(s);
    smag = 64'(si < 0 ? -si : si);
    if (n_acc < MAX_SAMPLES) begin
      n_acc   = n_acc + 1'b1;
      sum_acc = sum_acc + {{(smv_pkg::SUM_W-16){s[15]}}, s};
      sq_acc  = sq_acc + smag[smv_pkg::SQ_W-1:0] * smag[smv_pkg::SQ_W-1:0];
    end else begin
      ovf_acc = 1'b1;
    end
    if (!lst) return;

    nn    = 64'(n_acc);
    neg   = sum_acc[smv_pkg::SUM_W-1];
    mag33 = neg ? -sum_acc : sum_acc;
    mag   = 64'(mag33);
    mq    = (nn != 0) ? (mag << FRAC) / nn : 64'd0;
    mean  = neg ? -mq : mq;
    var_v = 64'd0;
    if (nn >= 2) begin
      d     = nn * 64'(sq_acc) - mag * mag;
      m     = nn * (nn - 64'd1);
      q     = d / m;
      r     = d % m;
      var_v = (q << FRAC) + ((r << FRAC) / m);
    end
    st.mean_value     = mean[smv_pkg::MEAN_W-1:0];
    st.variance_value = var_v[smv_pkg::VAR_W-1:0];
    st.variance_valid = (nn >= 2);
    st.sample_count   = n_acc;
    st.count_overflow = ovf_acc;
    stats_q.push_back(st);
    clear_set();
  endfunction

  // Compare a result word field by field with the oldest expectation
  function void check_result(set_stats_t got);
    set_stats_t exp_s;
    if (stats_q.size() == 0) begin
      $display("%0t: result word with none expected: mean %0d variance %0d count %0d",
               $time, got.mean_value, got.variance_value, got.sample_count);
      errors++;
      return;
    end
    exp_s = stats_q.pop_front();
    if (got.mean_value !== exp_s.mean_value) begin
      $display("%0t: mean_value expected %0d actual %0d",
               $time, exp_s.mean_value, got.mean_value);
      errors++;
    end
    if (got.variance_value !== exp_s.variance_value) begin
      $display("%0t: variance_value expected %0d actual %0d",
               $time, exp_s.variance_value, got.variance_value);
      errors++;
    end
    if (got.variance_valid !== exp_s.variance_valid) begin
      $display("%0t: variance_valid expected %0b actual %0b",
               $time, exp_s.variance_valid, got.variance_valid);
      errors++;
    end
    if (got.sample_count !== exp_s.sample_count) begin
      $display("%0t: sample_count expected %0d actual %0d",
               $time, exp_s.sample_count, got.sample_count);
      errors++;
    end
    if (got.count_overflow !== exp_s.count_overflow) begin
      $display("%0t: count_overflow expected %0b actual %0b",
               $time, exp_s.count_overflow, got.count_overflow);
      errors++;
    end
  endfunction
endclass

module tb;
  import smv_pkg::*;

  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam logic signed [15:0] S_MAX = 16'sh7fff;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 450;

  logic clk_i;
  logic rst_ni;
  bit   steady;    // no idling on either side
  bit   hold_req;  // receiver holds off for a long stretch

  mean_var_scoreboard stats_sb = new();

  smv_in_if  in_ch ();
  smv_out_if out_ch ();

  sample_mean_variance_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, steady stretches, one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  // Result monitor
  initial begin
    set_stats_t got;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.mean_value     = out_ch.mean_value;
        got.variance_value = out_ch.variance_value;
        got.variance_valid = out_ch.variance_valid;
        got.sample_count   = out_ch.sample_count;
        got.count_overflow = out_ch.count_overflow;
        stats_sb.check_result(got);
      end
    end
  end

  // Watchdog: cycles without any word moving
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall = 0;
      else
        stall++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one sample word, with random idle cycles ahead of it unless steady
  task automatic put_sample(input logic signed [15:0] s, input bit lst);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_ch.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_ch.valid  = 1'b1;
    in_ch.sample = s;
    in_ch.last   = lst;
    do @(posedge clk_i); while (!in_ch.ready);
    stats_sb.note_sample(s, lst);
    @(negedge clk_i);
  endtask

  // Mix of extremes, small values and full-range values
  function automatic logic signed [15:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8)  return S_MIN;
    if (sel < 16) return S_MAX;
    if (sel < 20) return 16'sd0;
    if (sel < 24) return -16'sd1;
    if (sel < 50) return 16'($urandom_range(32)) - 16'sd16;
    return 16'($urandom);
  endfunction

  // One set of random size and content
  task automatic put_random_set(inout int sent);
    int unsigned sel, len;
    logic signed [15:0] base;
    bit near_base;
    sel = $urandom_range(99);
    if (sel < 15)      len = 1;
    else if (sel < 55) len = $urandom_range(4, 2);
    else if (sel < 88) len = $urandom_range(16, 5);
    else               len = $urandom_range(64, 17);
    // some sets cluster around one value for small variances
    near_base = ($urandom_range(99) < 20);
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      if (near_base)
        put_sample(base + 16'($urandom_range(3)), i == len - 1);
      else
        put_sample(pick_sample(), i == len - 1);
    end
    sent += len;
  endtask

  // Stimulus
  initial begin
    int sent;
    rst_ni       = 1'b0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single samples at the extremes, pairs, negative truncation
    put_sample(16'sd0, 1'b1);
    put_sample(S_MIN, 1'b1);
    put_sample(S_MAX, 1'b1);
    put_sample(S_MAX, 1'b0);
    put_sample(S_MIN, 1'b1);
    put_sample(S_MIN, 1'b0);
    put_sample(S_MIN, 1'b1);
    put_sample(-16'sd1, 1'b0);
    put_sample(16'sd0, 1'b0);
    put_sample(16'sd0, 1'b1);
    put_sample(16'sd1, 1'b0);
    put_sample(16'sd0, 1'b0);
    put_sample(16'sd0, 1'b1);
    put_sample(S_MAX, 1'b0);
    put_sample(S_MAX, 1'b0);
    put_sample(S_MIN, 1'b0);
    put_sample(S_MIN, 1'b0);
    put_sample(S_MAX, 1'b1);
    put_sample(16'sd5, 1'b0);
    put_sample(16'sd5, 1'b0);
    put_sample(16'sd5, 1'b0);
    put_sample(16'sd6, 1'b1);

    // Random sets with idling on both sides
    sent = 0;
    while (sent < RANDOM_ITEMS * 2 / 3) put_random_set(sent);

    // Receiver holds off while short sets keep coming: input must stall
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) put_sample(pick_sample(), i == 2);
    end
    sent += 12;

    // Stretch with no idling at all
    while (sent < RANDOM_ITEMS - 40) put_random_set(sent);
    steady = 1'b0;
    while (sent < RANDOM_ITEMS) put_random_set(sent);
    in_ch.valid = 1'b0;

    // Drain
    while (stats_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (stats_sb.errors == 0 && stats_sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
